>>> hdl/tcg_pkg.sv
// Package: payload types, register indexes, hash constants and shared arithmetic helpers.
package tcg_pkg;

    typedef struct packed {
        logic signed [23:0] column_x;
        logic signed [23:0] column_z;
        logic [7:0]         layer_y;
    } voxel_t;

    typedef struct packed {
        logic [7:0]  block_code;
        logic [7:0]  surface_height;
        logic [15:0] noise_level;
    } result_t;

    typedef struct packed {
        logic split;
        logic hash;
        logic blend_x;
        logic blend_z;
    } lane_en_t;

    typedef enum logic [3:0] {
        REG_SEED         = 4'd0,
        REG_TERRAIN_MODE = 4'd1,
        REG_BASE_HEIGHT  = 4'd2,
        REG_HEIGHT_SCALE = 4'd3,
        REG_NOISE_SCALE  = 4'd4,
        REG_STONE_CODE   = 4'd5,
        REG_DIRT_CODE    = 4'd6,
        REG_GRASS_CODE   = 4'd7
    } reg_index_t;

    localparam logic [31:0] HASH_KX = 32'd374761393;
    localparam logic [31:0] HASH_KZ = 32'd1274126177;

    localparam int HBITS = 29;

    function automatic logic [15:0] hash_finish(input logic [HBITS-1:0] h);
        logic [15:0] g;
        g = h[15:0] ^ h[28:13];
        return g * HASH_KZ[15:0];
    endfunction

    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] s);
        logic signed [16:0] d;
        logic signed [33:0] p;
        logic signed [17:0] r;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, s});
        r = $signed({2'b00, a}) + p[33:16];
        return r[15:0];
    endfunction

endpackage

>>> hdl/tcg_octave.sv
// One octave lane of the value noise: cell hash, smoothstep and bilinear blend.
module tcg_octave #(
    parameter int OCTAVE = 0
) (
    input  logic              clk,
    input  tcg_pkg::lane_en_t lane_en,
    input  logic signed [39:0] px,
    input  logic signed [39:0] pz,
    input  logic [31:0]       seed,
    output logic [15:0]       noise
);
    import tcg_pkg::*;

    logic signed [47:0] psx, psz;
    logic [HBITS-1:0]   cx, cz;
    logic [15:0]        fx, fz;

    logic [HBITS-1:0] ax_reg, bz_reg;
    logic [15:0]      fx_reg, fz_reg;
    logic [31:0]      ffx_reg, ffz_reg;

    logic [HBITS-1:0] ax1, bz1, s29;
    logic [17:0]      tx, tz;
    logic [49:0]      smx, smz;

    logic [15:0] c00_reg, c10_reg, c01_reg, c11_reg, sx_reg, sz_reg;
    logic [15:0] h0_reg, h1_reg, sz2_reg, noise_reg;

    always_comb
    begin
        psx = {{8{px[39]}}, px} <<< OCTAVE;
        psz = {{8{pz[39]}}, pz} <<< OCTAVE;
        cx  = psx[16+HBITS-1:16];
        cz  = psz[16+HBITS-1:16];
        fx  = psx[15:0];
        fz  = psz[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (lane_en.split)
        begin
            ax_reg  <= cx * HASH_KX[HBITS-1:0];
            bz_reg  <= cz * HASH_KZ[HBITS-1:0];
            fx_reg  <= fx;
            fz_reg  <= fz;
            ffx_reg <= fx * fx;
            ffz_reg <= fz * fz;
        end
    end

    always_comb
    begin
        ax1 = ax_reg + HASH_KX[HBITS-1:0];
        bz1 = bz_reg + HASH_KZ[HBITS-1:0];
        s29 = seed[HBITS-1:0] + HBITS'(OCTAVE);
        tx  = 18'd196608 - {1'b0, fx_reg, 1'b0};
        tz  = 18'd196608 - {1'b0, fz_reg, 1'b0};
        smx = ffx_reg * tx;
        smz = ffz_reg * tz;
    end

    always_ff @(posedge clk)
    begin
        if (lane_en.hash)
        begin
            c00_reg <= hash_finish(s29 ^ ax_reg ^ bz_reg);
            c10_reg <= hash_finish(s29 ^ ax1 ^ bz_reg);
            c01_reg <= hash_finish(s29 ^ ax_reg ^ bz1);
            c11_reg <= hash_finish(s29 ^ ax1 ^ bz1);
            sx_reg  <= smx[47:32];
            sz_reg  <= smz[47:32];
        end
        if (lane_en.blend_x)
        begin
            h0_reg  <= lerp16(c00_reg, c10_reg, sx_reg);
            h1_reg  <= lerp16(c01_reg, c11_reg, sx_reg);
            sz2_reg <= sz_reg;
        end
        if (lane_en.blend_z)
        begin
            noise_reg <= lerp16(h0_reg, h1_reg, sz2_reg);
        end
    end

    assign noise = noise_reg;

endmodule

>>> hdl/terrain_column_generator.sv
// Top level: terrain column generator pipeline with configuration registers.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one voxel position per
//   transaction; output channel out_valid/out_stall/out_data returns its block
//   code, surface height and noise level, in order, one result per input.
//   Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
//   always high, unknown indexes are dropped. Write only while the pipeline is empty.
// Timing:
//   Eight register stages; out_valid rises when an accepted transaction reaches the last.
//   Throughput is one transaction per cycle while out_stall is low; the octave lanes run in parallel.
//   The hash stage holds two 32x18 smoothstep multiplies per lane, one for each axis.
// Stall:
//   Empty stages fill even while the output is stalled; in_stall rises only once
//   a stalled result has every stage in front of it occupied. Nothing is dropped.
// Reset:
//   rst_n clears all stage valid bits and loads the register defaults
//   (seed 0, noise mode, base 64, scale 32, noise scale 1311, codes 1/2/3).
module terrain_column_generator #(
    parameter int COLUMN_HEIGHT = 256,
    parameter int OCTAVES       = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tcg_pkg::voxel_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output tcg_pkg::result_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import tcg_pkg::*;

    localparam int NS   = 8;
    localparam int N    = 16 + OCTAVES;
    localparam longint DIV  = (64'd1 << OCTAVES) - 64'd1;
    localparam int LOGD = (OCTAVES == 1) ? 0 : OCTAVES;
    localparam int SH   = N + LOGD;
    localparam int MW   = N + 2;
    localparam longint RECIP = ((64'd1 << SH) + DIV - 64'd1) / DIV;
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
    localparam logic [9:0] TOP_LAYER = 10'(COLUMN_HEIGHT - 1);
    localparam logic [9:0] CH_C = 10'(COLUMN_HEIGHT);

    logic [31:0] seed_reg;
    logic        mode_reg;
    logic [7:0]  base_reg, hscale_reg, stone_reg, dirt_reg, grass_reg;
    logic [15:0] nscale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            mode_reg   <= 1'b0;
            base_reg   <= 8'd64;
            hscale_reg <= 8'd32;
            nscale_reg <= 16'd1311;
            stone_reg  <= 8'd1;
            dirt_reg   <= 8'd2;
            grass_reg  <= 8'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEED:         seed_reg   <= cfg_data;
                REG_TERRAIN_MODE: mode_reg   <= cfg_data[0];
                REG_BASE_HEIGHT:  base_reg   <= cfg_data[7:0];
                REG_HEIGHT_SCALE: hscale_reg <= cfg_data[7:0];
                REG_NOISE_SCALE:  nscale_reg <= cfg_data[15:0];
                REG_STONE_CODE:   stone_reg  <= cfg_data[7:0];
                REG_DIRT_CODE:    dirt_reg   <= cfg_data[7:0];
                REG_GRASS_CODE:   grass_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage control: a stage loads when empty or when the one after it loads
    logic [NS-1:0] v_reg, en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    // layer index shift line
    logic [7:0] y_reg [NS-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
            y_reg[0] <= in_data.layer_y;
        for (int i = 1; i < NS - 1; i++)
            if (en[i])
                y_reg[i] <= y_reg[i-1];
    end

    // stage 1: world to noise space
    logic signed [40:0] pxw, pzw;
    logic signed [39:0] px_reg, pz_reg;

    always_comb
    begin
        pxw = in_data.column_x * $signed({1'b0, nscale_reg});
        pzw = in_data.column_z * $signed({1'b0, nscale_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= pxw[39:0];
            pz_reg <= pzw[39:0];
        end
    end

    // stages 2 to 5: octave lanes
    lane_en_t    lane_en;
    logic [15:0] noise [OCTAVES];

    assign lane_en = '{split: en[1], hash: en[2], blend_x: en[3], blend_z: en[4]};

    for (genvar g = 0; g < OCTAVES; g++)
    begin : g_oct
        tcg_octave #(.OCTAVE(g)) u_oct (
            .clk     (clk),
            .lane_en (lane_en),
            .px      (px_reg),
            .pz      (pz_reg),
            .seed    (seed_reg),
            .noise   (noise[g])
        );
    end

    // stage 6: weighted sum times reciprocal of total weight
    logic [N-1:0]    acc;
    logic [N+MW-1:0] prod_reg;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < OCTAVES; i++)
            acc = acc + (N'(noise[i]) << (OCTAVES - 1 - i));
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
            prod_reg <= acc * RECIP_C;
    end

    // stage 7: level and height product
    logic [15:0] level, level_reg;
    logic [23:0] hp_reg;

    assign level = prod_reg[SH+15:SH];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            level_reg <= level;
            hp_reg    <= level * hscale_reg;
        end
    end

    // stage 8: height clamp and layer classification
    logic [24:0] qsum;
    logic [9:0]  hraw, height, ylay, depth;
    result_t     res, out_reg;

    always_comb
    begin
        qsum  = {1'b0, hp_reg} + 25'(hp_reg[23:16]) + 25'd1;
        ylay  = {2'b00, y_reg[NS-2]};
        if (mode_reg)
        begin
            hraw   = {2'b00, base_reg};
            height = (hraw > TOP_LAYER) ? TOP_LAYER : hraw;
            depth  = 10'd3;
        end
        else
        begin
            hraw   = {2'b00, base_reg} + {2'b00, qsum[23:16]};
            height = (hraw > TOP_LAYER) ? TOP_LAYER : ((hraw < 10'd1) ? 10'd1 : hraw);
            depth  = 10'd4;
        end
        if (ylay >= CH_C)
            res.block_code = '0;
        else if (ylay == 10'd0)
            res.block_code = stone_reg;
        else if (ylay + depth < height)
            res.block_code = stone_reg;
        else if (ylay < height)
            res.block_code = dirt_reg;
        else if (ylay == height)
            res.block_code = grass_reg;
        else
            res.block_code = '0;
        res.surface_height = height[7:0];
        res.noise_level    = mode_reg ? 16'd0 : level_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
            out_reg <= res;
    end

    assign out_data = out_reg;

`ifndef SYNTH
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (10'(out_data.surface_height) <= TOP_LAYER))
        else $error("surface height above column");

    a_rose_from_prev: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v_reg[NS-2]))
        else $error("result appeared without a transaction in the stage before");
`endif

endmodule

>>> tb/terrain_column_generator_test.sv
// Testbench: terrain column generator, checked against a built-in fractal value noise predictor.
module terrain_column_generator_test;
    import tcg_pkg::*;

    localparam int COL_H = 256;
    localparam int OCT = 4;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    voxel_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    result_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0] seed_r;
    logic mode_r;
    logic [7:0] base_r, hscale_r, stone_r, dirt_r, grass_r;
    logic [15:0] nscale_r;

    result_t expected_q[$];
    int mismatches = 0;
    longint cycles = 0;
    bit quiet = 1'b0;

    terrain_column_generator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [15:0] corner(input logic [31:0] cx, input logic [31:0] cz,
                                           input logic [31:0] s);
        logic [31:0] h;
        h = s ^ (cx * 32'd374761393) ^ (cz * 32'd1274126177);
        h = (h ^ (h >> 13)) * 32'd1274126177;
        return h[15:0];
    endfunction

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] s);
        logic [63:0] r;
        r = 64'(a) * (64'd65536 - 64'(s)) + 64'(b) * 64'(s);
        return r[31:16];
    endfunction

    function automatic logic [15:0] ease(input logic [15:0] f);
        logic [63:0] t;
        t = 64'(f) * 64'(f) * (64'd196608 - 2 * 64'(f));
        return t[47:32];
    endfunction

    function automatic logic [15:0] octave_noise(input longint px, input longint pz,
                                                 input logic [31:0] s);
        logic [31:0] cx, cz;
        logic [15:0] fx, fz, h0, h1;
        longint qx, qz;
        qx = px >>> 16;
        qz = pz >>> 16;
        cx = qx[31:0];
        cz = qz[31:0];
        fx = ease(px[15:0]);
        fz = ease(pz[15:0]);
        h0 = blend(corner(cx, cz, s), corner(cx + 1, cz, s), fx);
        h1 = blend(corner(cx, cz + 1, s), corner(cx + 1, cz + 1, s), fx);
        return blend(h0, h1, fz);
    endfunction

    function automatic result_t predict_voxel(input voxel_t v);
        result_t r;
        longint px, pz, acc, h;
        int depth, y;
        logic [7:0] code;
        px = longint'(v.column_x) * longint'({1'b0, nscale_r});
        pz = longint'(v.column_z) * longint'({1'b0, nscale_r});
        acc = 0;
        r.noise_level = '0;
        if (mode_r)
        begin
            h = base_r;
            if (h > COL_H - 1) h = COL_H - 1;
            depth = 3;
        end
        else
        begin
            for (int i = 0; i < OCT; i++)
                acc += longint'(octave_noise(px <<< i, pz <<< i, seed_r + i)) << (OCT - 1 - i);
            acc = acc / ((1 << OCT) - 1);
            r.noise_level = acc[15:0];
            h = base_r + (acc * hscale_r) / 65535;
            if (h > COL_H - 1) h = COL_H - 1;
            if (h < 1) h = 1;
            depth = 4;
        end
        y = v.layer_y;
        if (y >= COL_H) code = 8'd0;
        else if (y == 0) code = stone_r;
        else if (y < h - depth) code = stone_r;
        else if (y < h) code = dirt_r;
        else if (y == h) code = grass_r;
        else code = 8'd0;
        r.block_code = code;
        r.surface_height = h[7:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && !quiet)
            out_stall <= ($urandom_range(99) < 8);
        else
            out_stall <= 1'b0;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                result_t e;
                e = expected_q.pop_front();
                if (out_data.block_code !== e.block_code)
                    report_mismatch("block_code", out_data.block_code, e.block_code);
                if (out_data.surface_height !== e.surface_height)
                    report_mismatch("surface_height", out_data.surface_height,
                                    e.surface_height);
                if (out_data.noise_level !== e.noise_level)
                    report_mismatch("noise_level", out_data.noise_level, e.noise_level);
            end
        end
    end

    task automatic send_voxel(input logic signed [23:0] x, input logic signed [23:0] z,
                              input logic [7:0] y);
        voxel_t v;
        v.column_x = x;
        v.column_z = z;
        v.layer_y = y;
        while (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q = {expected_q, predict_voxel(v)};
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SEED:         seed_r = val;
            REG_TERRAIN_MODE: mode_r = val[0];
            REG_BASE_HEIGHT:  base_r = val[7:0];
            REG_HEIGHT_SCALE: hscale_r = val[7:0];
            REG_NOISE_SCALE:  nscale_r = val[15:0];
            REG_STONE_CODE:   stone_r = val[7:0];
            REG_DIRT_CODE:    dirt_r = val[7:0];
            REG_GRASS_CODE:   grass_r = val[7:0];
            default: ;
        endcase
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            logic signed [23:0] x, z;
            x = 24'($urandom);
            z = 24'($urandom);
            if ($urandom_range(3) == 0)
            begin
                x = $signed(24'($urandom_range(64))) - 24'sd32;
                z = $signed(24'($urandom_range(64))) - 24'sd32;
            end
            send_voxel(x, z, 8'($urandom));
        end
    endtask

    task automatic test_directed_defaults;
        send_voxel(24'sh7FFFFF, 24'sh7FFFFF, 8'd255);
        send_voxel(-24'sh800000, -24'sh800000, 8'd0);
        send_voxel(24'sh7FFFFF, -24'sh800000, 8'd64);
        send_voxel(24'sd0, 24'sd0, 8'd1);
        send_voxel(-24'sd1, -24'sd1, 8'd60);
        for (int y = 58; y < 74; y += 2)
            send_voxel(24'sd5, -24'sd7, y[7:0]);
        drain();
    endtask

    task automatic test_flat_terrain;
        write_reg(REG_TERRAIN_MODE, 32'd1);
        write_reg(REG_BASE_HEIGHT, 32'd255);
        write_reg(REG_STONE_CODE, 32'hFF);
        write_reg(REG_DIRT_CODE, 32'h00);
        write_reg(REG_GRASS_CODE, 32'hAA);
        send_voxel(24'sd0, 24'sd0, 8'd251);
        send_voxel(24'sd0, 24'sd0, 8'd252);
        send_voxel(24'sd0, 24'sd0, 8'd254);
        send_voxel(24'sd0, 24'sd0, 8'd255);
        drain();
        write_reg(REG_BASE_HEIGHT, 32'd0);
        send_voxel(24'sd1, 24'sd1, 8'd0);
        send_voxel(24'sd1, 24'sd1, 8'd1);
        drain();
        write_reg(REG_BASE_HEIGHT, 32'd20);
        send_random(60);
        drain();
    endtask

    task automatic test_noise_settings;
        logic [31:0] seeds[4] = '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'h0, 32'h5A5A1234};
        write_reg(REG_TERRAIN_MODE, 32'd0);
        write_reg(reg_index_t'(4'd9), 32'hFFFFFFFF);
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_SEED, p < 4 ? seeds[p] : $urandom);
            write_reg(REG_BASE_HEIGHT, p == 0 ? 0 : (p == 1 ? 255 : $urandom_range(255)));
            write_reg(REG_HEIGHT_SCALE, p == 0 ? 0 : (p == 2 ? 255 : $urandom_range(255)));
            write_reg(REG_NOISE_SCALE, p == 3 ? 16'hFFFF : (p == 4 ? 0 : $urandom));
            write_reg(REG_STONE_CODE, $urandom);
            write_reg(REG_DIRT_CODE, $urandom);
            write_reg(REG_GRASS_CODE, $urandom);
            quiet = (p == 5);
            send_random(90);
            drain();
            quiet = 1'b0;
        end
    endtask

    initial
    begin
        seed_r = 0; mode_r = 0; base_r = 64; hscale_r = 32; nscale_r = 1311;
        stone_r = 1; dirt_r = 2; grass_r = 3;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_flat_terrain();
        test_noise_settings();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> sim.f
hdl/tcg_pkg.sv
hdl/tcg_octave.sv
hdl/terrain_column_generator.sv
tb/terrain_column_generator_test.sv
